// ----- hdl/bill_credit_handshake_defines.svh -----
// Assertion macros for the bill credit handshake block.
// Included by the modules that carry assertions; empty bodies when SYNTH is defined.
`ifndef BILL_CREDIT_HANDSHAKE_DEFINES_SVH
`define BILL_CREDIT_HANDSHAKE_DEFINES_SVH
`ifndef SYNTH
// lbl: label, ck: clock, rn: active-low reset, ante: antecedent, cons: consequent
`define BCH_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bch assertion failed");
`define BCH_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bch assertion failed");
`else
`define BCH_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define BCH_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/bch_pkg.sv -----
// Shared types and constants for the bill credit handshake block.
// No dependencies.
package bch_pkg;

  localparam int HOLD_W    = 16;
  localparam int SHORT_W   = 8;
  localparam int DENOM_W   = 3;
  localparam int VEND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [HOLD_W-1:0]  HOLD_RST    = 16'd280;
  localparam logic [SHORT_W-1:0] POLL_RST    = 8'd2;
  localparam logic [SHORT_W-1:0] LIMIT_RST   = 8'd10;
  localparam logic [SHORT_W-1:0] RELEASE_RST = 8'd10;
  localparam logic [VEND_W-1:0]  VEND_HIGH   = 3'h7;
  localparam logic [VEND_W-1:0]  VEND_LOW    = 3'h0;
  localparam logic [SHORT_W-1:0] CNT_MAX     = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD    = 2'd0,
    REG_POLL    = 2'd1,
    REG_LIMIT   = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HOLD_LOW  = 3'd1,
    PH_POLL      = 3'd2,
    PH_WAIT_HIGH = 3'd3,
    PH_HOLD_ZERO = 3'd4,
    PH_HOLD_CODE = 3'd5,
    PH_RELEASE   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ABORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold_ticks;
    logic [SHORT_W-1:0] poll_ticks;
    logic [SHORT_W-1:0] poll_limit;
    logic [SHORT_W-1:0] release_ticks;
  } cfg_t;

  typedef struct packed {
    logic               ack_level;
    logic [DENOM_W-1:0] denom;
    logic               start_req;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [VEND_W-1:0] vend_lines;
    logic              busy_level;
  } res_t;

endpackage

// ----- hdl/bch_cfg.sv -----
// Configuration register bank for the bill credit handshake block.
// Depends on bch_pkg.
module bch_cfg import bch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks    <= HOLD_RST;
      cfg_r.poll_ticks    <= POLL_RST;
      cfg_r.poll_limit    <= LIMIT_RST;
      cfg_r.release_ticks <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HOLD:    cfg_r.hold_ticks    <= cfg_wdata[HOLD_W-1:0];
        REG_POLL:    cfg_r.poll_ticks    <= cfg_wdata[SHORT_W-1:0];
        REG_LIMIT:   cfg_r.poll_limit    <= cfg_wdata[SHORT_W-1:0];
        REG_RELEASE: cfg_r.release_ticks <= cfg_wdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bch_seq.sv -----
// Credit handshake sequencer: phase, tick timer, poll counter and line registers.
// Depends on bch_pkg and bill_credit_handshake_defines.svh.
`include "bill_credit_handshake_defines.svh"
module bch_seq import bch_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res_nxt
);

  localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  phase_t                  phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt, timer_dec;
  logic [SHORT_W-1:0]      cnt_r, cnt_nxt;
  logic [VEND_W-1:0]       code_r, code_nxt;
  logic                    busy_r, busy_nxt;
  logic [VEND_W-1:0]       vend_r, vend_nxt;
  logic                    expired;
  logic [TIMER_BITS-1:0]   hold_ld, poll_ld, rel_ld;
  status_t                 status;

  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [31:0] v);
    return (v > TMAX) ? TMAX[TIMER_BITS-1:0] : v[TIMER_BITS-1:0];
  endfunction

  assign hold_ld   = sat_load(32'(cfg.hold_ticks));
  assign poll_ld   = sat_load(32'(cfg.poll_ticks));
  assign rel_ld    = sat_load(32'(cfg.release_ticks));
  assign expired   = (timer_r <= TIMER_BITS'(1));
  assign timer_dec = expired ? '0 : timer_r - TIMER_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    busy_nxt  = busy_r;
    vend_nxt  = vend_r;
    status    = ST_BUSY;
    unique case (phase_r)
      PH_HOLD_LOW: begin
        timer_nxt = timer_dec;
        if (expired) begin
          vend_nxt  = code_r;
          cnt_nxt   = '0;
          timer_nxt = TIMER_BITS'(1);
          phase_nxt = PH_POLL;
        end
      end
      PH_POLL: begin
        timer_nxt = timer_dec;
        if (expired) begin
          if (!item.ack_level) begin
            phase_nxt = PH_WAIT_HIGH;
          end else if (cnt_r > cfg.poll_limit) begin
            busy_nxt  = 1'b1;
            vend_nxt  = VEND_HIGH;
            phase_nxt = PH_IDLE;
            status    = ST_ABORT;
          end else begin
            if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + SHORT_W'(1);
            timer_nxt = poll_ld;
          end
        end
      end
      PH_WAIT_HIGH: begin
        if (item.ack_level) begin
          vend_nxt  = VEND_LOW;
          timer_nxt = hold_ld;
          phase_nxt = PH_HOLD_ZERO;
        end
      end
      PH_HOLD_ZERO: begin
        timer_nxt = timer_dec;
        if (expired) begin
          vend_nxt  = code_r;
          timer_nxt = hold_ld;
          phase_nxt = PH_HOLD_CODE;
        end
      end
      PH_HOLD_CODE: begin
        timer_nxt = timer_dec;
        if (expired) begin
          vend_nxt = VEND_HIGH;
          if (cfg.release_ticks == '0) begin
            busy_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
            status    = ST_DONE;
          end else begin
            timer_nxt = rel_ld;
            phase_nxt = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        timer_nxt = timer_dec;
        if (expired) begin
          busy_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
          status    = ST_DONE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item.start_req) begin
          code_nxt  = ~item.denom;
          busy_nxt  = 1'b0;
          vend_nxt  = VEND_LOW;
          timer_nxt = hold_ld;
          phase_nxt = PH_HOLD_LOW;
        end else begin
          status = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      cnt_r   <= '0;
      code_r  <= VEND_HIGH;
      busy_r  <= 1'b1;
      vend_r  <= VEND_HIGH;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
      busy_r  <= busy_nxt;
      vend_r  <= vend_nxt;
    end
  end

  assign res_nxt.busy_level = busy_nxt;
  assign res_nxt.vend_lines = vend_nxt;
  assign res_nxt.status     = status;

  `BCH_ASSERT_SAME(a_idle_busy_high, clk, rst_n, phase_r == PH_IDLE, busy_r)
  `BCH_ASSERT_SAME(a_active_busy_low, clk, rst_n, phase_r != PH_IDLE, !busy_r)
  `BCH_ASSERT_SAME(a_poll_shows_code, clk, rst_n,
                   phase_r == PH_POLL || phase_r == PH_WAIT_HIGH, vend_r == code_r)
  `BCH_ASSERT_NEXT(a_end_to_idle, clk, rst_n,
                   step_en && (status == ST_DONE || status == ST_ABORT),
                   phase_r == PH_IDLE && vend_r == VEND_HIGH)

endmodule

// ----- hdl/bill_credit_handshake.sv -----
// Bill credit handshake: one tick item in, one line-level result out per item.
// Throughput is one item per clock while a full result register is not held by a low out_tready.
// An accepted item is registered in the input register, stepped through the sequencer into the
// result register and then offered on out_tdata; a full result register that out_tready does
// not take stalls the step. The sequencer advances at most one step per item, and in_tready
// follows out_tready only when both the input and the result register are full.
// Depends on bch_pkg, bch_cfg and bch_seq.
module bill_credit_handshake import bch_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] start_req, [3:1] denom, [4] ack_level
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] busy_level, [3:1] vend_lines, [5:4] status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  logic  item_vld_r;
  res_t  res_nxt, res_r;
  logic  res_vld_r;
  logic  step_en;

  assign step_en   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (step_en) begin
        res_vld_r <= 1'b1;
      end else if (out_tready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    if (step_en) res_r <= res_nxt;
  end

  bch_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bch_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), res_r};

endmodule

// ----- test/credit_check_pkg.sv -----
// Scoreboard for the bill credit handshake testbench: tick-level predictor plus result check.
// Depends on bch_pkg for the item, result and register types.
package credit_check_pkg;
  import bch_pkg::*;

  class credit_scoreboard;
    cfg_t              regs;
    phase_t            ph;
    logic [HOLD_W-1:0] ticks_left;
    logic [SHORT_W-1:0] polls;
    logic [VEND_W-1:0] code;
    logic              busy;
    logic [VEND_W-1:0] vend;
    res_t              awaited[$];
    int                errors;
    int                accepted;

    function new();
      regs.hold_ticks    = HOLD_RST;
      regs.poll_ticks    = POLL_RST;
      regs.poll_limit    = LIMIT_RST;
      regs.release_ticks = RELEASE_RST;
      ph         = PH_IDLE;
      ticks_left = '0;
      polls      = '0;
      code       = VEND_HIGH;
      busy       = 1'b1;
      vend       = VEND_HIGH;
      errors     = 0;
      accepted   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] v);
      case (idx)
        REG_HOLD:    regs.hold_ticks    = v;
        REG_POLL:    regs.poll_ticks    = v[SHORT_W-1:0];
        REG_LIMIT:   regs.poll_limit    = v[SHORT_W-1:0];
        REG_RELEASE: regs.release_ticks = v[SHORT_W-1:0];
      endcase
    endfunction

    // one tick of a loaded wait; a zero load expires on the next tick like a one
    function bit expired();
      if (ticks_left > 1) begin
        ticks_left--;
        return 1'b0;
      end
      ticks_left = '0;
      return 1'b1;
    endfunction

    function res_t advance_tick(item_t it);
      res_t    r;
      status_t st;
      st = ST_BUSY;
      case (ph)
        PH_HOLD_LOW: begin
          if (expired()) begin
            vend       = code;
            polls      = '0;
            ticks_left = HOLD_W'(1);
            ph         = PH_POLL;
          end
        end
        PH_POLL: begin
          if (expired()) begin
            if (!it.ack_level) begin
              ph = PH_WAIT_HIGH;
            end else if (polls > regs.poll_limit) begin
              busy = 1'b1;
              vend = VEND_HIGH;
              ph   = PH_IDLE;
              st   = ST_ABORT;
            end else begin
              if (polls != CNT_MAX) polls++;
              ticks_left = HOLD_W'(regs.poll_ticks);
            end
          end
        end
        PH_WAIT_HIGH: begin
          if (it.ack_level) begin
            vend       = VEND_LOW;
            ticks_left = regs.hold_ticks;
            ph         = PH_HOLD_ZERO;
          end
        end
        PH_HOLD_ZERO: begin
          if (expired()) begin
            vend       = code;
            ticks_left = regs.hold_ticks;
            ph         = PH_HOLD_CODE;
          end
        end
        PH_HOLD_CODE: begin
          if (expired()) begin
            vend = VEND_HIGH;
            if (regs.release_ticks == 0) begin
              busy = 1'b1;
              ph   = PH_IDLE;
              st   = ST_DONE;
            end else begin
              ticks_left = HOLD_W'(regs.release_ticks);
              ph         = PH_RELEASE;
            end
          end
        end
        PH_RELEASE: begin
          if (expired()) begin
            busy = 1'b1;
            ph   = PH_IDLE;
            st   = ST_DONE;
          end
        end
        default: begin
          ph = PH_IDLE;
          if (it.start_req) begin
            code       = ~it.denom;
            busy       = 1'b0;
            vend       = VEND_LOW;
            ticks_left = regs.hold_ticks;
            ph         = PH_HOLD_LOW;
            st         = ST_BUSY;
          end else begin
            st = ST_IDLE;
          end
        end
      endcase
      r.busy_level = busy;
      r.vend_lines = vend;
      r.status     = st;
      return r;
    endfunction

    function void note_item(item_t it);
      awaited.push_back(advance_tick(it));
      accepted++;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
        return;
      end
      want = awaited.pop_front();
      if (got.busy_level !== want.busy_level)
        report($sformatf("busy %b, want %b", got.busy_level, want.busy_level));
      if (got.vend_lines !== want.vend_lines)
        report($sformatf("vend lines %b, want %b", got.vend_lines, want.vend_lines));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

endpackage

// ----- test/bill_credit_handshake_tb.sv -----
// Testbench for bill_credit_handshake: drives random and directed tick items with stalls,
// checks every result against the scoreboard's prediction. Depends on bch_pkg and credit_check_pkg.
module bill_credit_handshake_tb;
  import bch_pkg::*;
  import credit_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1350;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_wdata;

  credit_scoreboard sb = new();
  bit calm;
  bit gappy;
  int squeeze_count;

  bill_credit_handshake dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task send_tick(bit s, logic [DENOM_W-1:0] d, bit a);
    item_t it;
    it = '{ack_level: a, denom: d, start_req: s};
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  task put_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task apply_settings(logic [HOLD_W-1:0] h, logic [SHORT_W-1:0] p, logic [SHORT_W-1:0] l,
                      logic [SHORT_W-1:0] r);
    put_reg(REG_HOLD, h);
    put_reg(REG_POLL, {8'd0, p});
    put_reg(REG_LIMIT, {8'd0, l});
    put_reg(REG_RELEASE, {8'd0, r});
    cfg_we <= 1'b0;
  endtask

  task drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one credit send against a host that pulls ack low after a delay (never for give_up, unless
  // the poll limit is at its maximum) and lets it rise some ticks after the block starts waiting for the rise
  task run_credit(bit give_up);
    int window;
    int delay;
    int low_len;
    int t;
    int wh;
    bit a;
    window = (sb.regs.hold_ticks == 0 ? 1 : int'(sb.regs.hold_ticks))
           + (sb.regs.poll_ticks == 0 ? 1 : int'(sb.regs.poll_ticks))
             * (int'(sb.regs.poll_limit) + 1) + 2;
    if (sb.regs.poll_limit == CNT_MAX)
      delay = window + $urandom_range(5, 60);
    else if (give_up)
      delay = -1;
    else
      delay = $urandom_range(0, window + window / 4);
    low_len = $urandom_range(0, 6);
    send_tick(1'b1, DENOM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    t  = 1;
    wh = 0;
    while (sb.ph != PH_IDLE) begin
      if (sb.ph == PH_WAIT_HIGH) begin
        a = (wh >= low_len);
        wh++;
      end else if (sb.ph == PH_HOLD_LOW || sb.ph == PH_POLL) begin
        a = (delay < 0 || t < delay);
      end else begin
        a = 1'($urandom_range(0, 1));
      end
      send_tick($urandom_range(0, 3) == 0, DENOM_W'($urandom_range(0, 7)), a);
      t++;
    end
  endtask

  task idle_noise();
    repeat ($urandom_range(0, 3))
      send_tick(1'b0, DENOM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 11) == 0) begin
      send_tick(1'b1, DENOM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      while (sb.ph != PH_IDLE)
        send_tick(1'($urandom_range(0, 1)), DENOM_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // result side: checks and stalls
  initial begin
    int stall_left;
    int squeezes_done;
    stall_left    = 0;
    squeezes_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(res_t'(out_tdata[5:0]));
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (squeezes_done != squeeze_count) begin
        squeezes_done = squeeze_count;
        stall_left    = 79;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase_no;
    int nseq;
    int budget;
    logic [HOLD_W-1:0]  h;
    logic [SHORT_W-1:0] p;
    logic [SHORT_W-1:0] l;
    logic [SHORT_W-1:0] r;
    calm  = 1'b0;
    gappy = 1'b1;
    squeeze_count = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_HOLD;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero settings: timeout, start while busy, zero code, zero release
    apply_settings(16'd0, 8'd0, 8'd0, 8'd0);
    send_tick(1'b0, 3'd7, 1'b0);
    send_tick(1'b1, 3'd0, 1'b1);
    send_tick(1'b0, 3'd5, 1'b1);
    send_tick(1'b1, 3'd3, 1'b1);
    send_tick(1'b0, 3'd0, 1'b1);
    send_tick(1'b1, 3'd7, 1'b0);
    send_tick(1'b0, 3'd1, 1'b1);
    send_tick(1'b1, 3'd6, 1'b0);
    send_tick(1'b0, 3'd7, 1'b0);
    send_tick(1'b0, 3'd0, 1'b1);
    send_tick(1'b1, 3'd1, 1'b0);
    send_tick(1'b0, 3'd4, 1'b1);
    send_tick(1'b0, 3'd3, 1'b0);

    budget   = sb.accepted + ITEMS - 120;
    phase_no = 0;
    while (sb.accepted < budget) begin
      drain_results();
      case (phase_no)
        2: begin
          h = 16'd1; p = 8'd1; l = CNT_MAX; r = 8'd255; nseq = 1;
        end
        3: begin
          h = 16'd3; p = 8'd255; l = 8'd0; r = 8'd0; nseq = 1;
        end
        default: begin
          h = HOLD_W'($urandom_range(0, 6));
          p = SHORT_W'($urandom_range(0, 4));
          l = SHORT_W'($urandom_range(0, 6));
          r = SHORT_W'($urandom_range(0, 6));
          nseq = $urandom_range(4, 10);
        end
      endcase
      apply_settings(h, p, l, r);
      gappy = 1'($urandom_range(0, 1));
      calm  = (sb.accepted >= budget - ITEMS / 4) || phase_no == 1;
      if (phase_no == 1) squeeze_count++;
      for (int i = 0; i < nseq; i++) begin
        run_credit(phase_no == 3 || $urandom_range(0, 5) == 0);
        idle_noise();
      end
      phase_no++;
    end

    // long hold, then give up at the first chance
    drain_results();
    apply_settings(16'd100, 8'd1, 8'd0, 8'd0);
    calm = 1'b1;
    run_credit(1'b1);
    drain_results();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bch_pkg.sv
hdl/bch_cfg.sv
hdl/bch_seq.sv
hdl/bill_credit_handshake.sv
test/credit_check_pkg.sv
test/bill_credit_handshake_tb.sv
